/* rtl/ps2hfe_pkg.sv */
// ps2hfe_pkg: shared types and codes for the ps2 host frame engine
// no dependencies; imported by ps2_host_frame_engine_unit
package ps2hfe_pkg;

  localparam int DATA_BITS = 8;

  localparam logic [1:0] REQ_RX_BIT  = 2'd0;
  localparam logic [1:0] REQ_TIMEOUT = 2'd1;
  localparam logic [1:0] REQ_SEND    = 2'd2;

  localparam logic [1:0] PHASE_IDLE   = 2'd0;
  localparam logic [1:0] PHASE_DATA   = 2'd1;
  localparam logic [1:0] PHASE_PARITY = 2'd2;
  localparam logic [1:0] PHASE_STOP   = 2'd3;

  localparam logic KIND_RX = 1'b0;
  localparam logic KIND_TX = 1'b1;

  // results after the start bit: data bits, parity, release
  localparam logic [3:0] TX_TAIL = 4'(DATA_BITS + 2);

  typedef struct packed {
    logic [1:0] req_type;
    logic       rx_bit;
    logic [7:0] tx_byte;
  } in_item_t;

  typedef struct packed {
    logic       result_kind;
    logic       byte_valid;
    logic [7:0] rx_byte;
    logic       parity_error;
    logic       line_level;
    logic       last;
  } out_item_t;

  function automatic logic odd_parity(input logic [7:0] b);
    return ~(^b);
  endfunction

endpackage

/* rtl/ps2_host_frame_engine_unit.sv */
// ps2_host_frame_engine_unit: ps2 host frame machine with a serializing result register
// depends on ps2hfe_pkg
//
// Each item is a received data-line bit, a timeout tick or a send request. The frame
// state updates in the cycle the item is accepted, and the next item can follow at once
// when no earlier result is still waiting. A received bit yields one status item; a send
// request yields eleven drive items, one per cycle from the result register while
// out_ready is high, and the next input item is taken in the cycle the final drive item
// leaves. Timeout ticks produce no result.
module ps2_host_frame_engine_unit
  import ps2hfe_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic [1:0] phase_r, phase_nxt;
  logic [3:0] bit_count_r, bit_count_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic       timeout_r, timeout_nxt;
  logic       error_r, error_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic       kind_r, kind_nxt;
  logic       byte_valid_r, byte_valid_nxt;
  logic [7:0] rx_byte_r, rx_byte_nxt;
  logic       perr_r, perr_nxt;
  logic       level_r, level_nxt;
  logic [9:0] seq_r, seq_nxt;
  logic [3:0] rem_r, rem_nxt;

  logic       accept;
  logic       out_done;
  logic       rx_valid;
  logic [7:0] rx_byte;
  logic [3:0] count_inc;

  assign out_done = out_valid_r && out_ready;
  assign in_ready = !out_valid_r || (out_ready && rem_r == 4'd0);
  assign accept   = in_valid && in_ready;
  assign count_inc = bit_count_r + 4'd1;

  // frame state
  always_comb begin
    phase_nxt     = phase_r;
    bit_count_nxt = bit_count_r;
    shift_nxt     = shift_r;
    timeout_nxt   = timeout_r;
    error_nxt     = error_r;
    rx_valid      = 1'b0;
    rx_byte       = 8'd0;
    if (accept) begin
      case (in_data.req_type)
        REQ_RX_BIT: begin
          if (timeout_r || phase_r == PHASE_IDLE) begin
            if (!in_data.rx_bit) begin
              phase_nxt     = PHASE_DATA;
              bit_count_nxt = 4'd0;
              shift_nxt     = 8'd0;
            end
          end else if (phase_r == PHASE_DATA) begin
            if (in_data.rx_bit) begin
              shift_nxt = shift_r | (8'd1 << bit_count_r[2:0]);
            end
            bit_count_nxt = count_inc;
            if (count_inc >= 4'(DATA_BITS)) begin
              phase_nxt = PHASE_PARITY;
            end
          end else if (phase_r == PHASE_PARITY) begin
            if (in_data.rx_bit == odd_parity(shift_r)) begin
              rx_valid = 1'b1;
              rx_byte  = shift_r;
            end else begin
              error_nxt = 1'b1;
            end
            phase_nxt = PHASE_STOP;
          end else begin
            phase_nxt = PHASE_IDLE;
          end
          timeout_nxt = 1'b0;
        end
        REQ_TIMEOUT: timeout_nxt = 1'b1;
        REQ_SEND:    timeout_nxt = 1'b1;
        default: ;
      endcase
    end
  end

  // result register and transmit serializer
  always_comb begin
    out_valid_nxt  = out_valid_r;
    kind_nxt       = kind_r;
    byte_valid_nxt = byte_valid_r;
    rx_byte_nxt    = rx_byte_r;
    perr_nxt       = perr_r;
    level_nxt      = level_r;
    seq_nxt        = seq_r;
    rem_nxt        = rem_r;
    if (out_done) begin
      if (rem_r != 4'd0) begin
        level_nxt = seq_r[0];
        seq_nxt   = {1'b0, seq_r[9:1]};
        rem_nxt   = rem_r - 4'd1;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
    if (accept) begin
      case (in_data.req_type)
        REQ_RX_BIT: begin
          out_valid_nxt  = 1'b1;
          kind_nxt       = KIND_RX;
          byte_valid_nxt = rx_valid;
          rx_byte_nxt    = rx_byte;
          perr_nxt       = error_nxt;
          level_nxt      = 1'b1;
          rem_nxt        = 4'd0;
        end
        REQ_SEND: begin
          out_valid_nxt  = 1'b1;
          kind_nxt       = KIND_TX;
          byte_valid_nxt = 1'b0;
          rx_byte_nxt    = 8'd0;
          perr_nxt       = error_r;
          level_nxt      = 1'b0;
          seq_nxt        = {1'b1, odd_parity(in_data.tx_byte), in_data.tx_byte};
          rem_nxt        = TX_TAIL;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PHASE_IDLE;
      bit_count_r <= 4'd0;
      shift_r     <= 8'd0;
      timeout_r   <= 1'b0;
      error_r     <= 1'b0;
      out_valid_r <= 1'b0;
      rem_r       <= 4'd0;
    end else begin
      phase_r     <= phase_nxt;
      bit_count_r <= bit_count_nxt;
      shift_r     <= shift_nxt;
      timeout_r   <= timeout_nxt;
      error_r     <= error_nxt;
      out_valid_r <= out_valid_nxt;
      rem_r       <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    byte_valid_r <= byte_valid_nxt;
    rx_byte_r    <= rx_byte_nxt;
    perr_r       <= perr_nxt;
    level_r      <= level_nxt;
    seq_r        <= seq_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_data.result_kind  = kind_r;
  assign out_data.byte_valid   = byte_valid_r;
  assign out_data.rx_byte      = rx_byte_r;
  assign out_data.parity_error = perr_r;
  assign out_data.line_level   = level_r;
  assign out_data.last         = (rem_r == 4'd0);

  // a pending drive sequence only exists behind a transmit item
  a_rem_tx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && rem_r != 4'd0) |-> (kind_r == KIND_TX && !byte_valid_r))
    else $error("drive sequence pending on a non-transmit item");

  // the final drive item always releases the line
  a_release: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == KIND_TX && rem_r == 4'd0) |-> level_r)
    else $error("final drive item does not release the line");

  // a send step advances the countdown by one
  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_done && rem_r != 4'd0) |=> (rem_r == $past(rem_r) - 4'd1))
    else $error("drive countdown skipped");

  // the sticky error never clears outside reset
  a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    error_r |=> error_r)
    else $error("parity error flag cleared");

endmodule

/* verif/tb_ps2_host_frame_engine_unit.sv */
// tb_ps2_host_frame_engine_unit: self-checking testbench for the ps2 host frame engine
// depends on ps2hfe_pkg and ps2_host_frame_engine_unit; predicts frame results and checks them
// in order, with random idling on both channels and a long result-side stall
`timescale 1ns / 1ps

module tb_ps2_host_frame_engine_unit;
  import ps2hfe_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int IDLE_PCT = 9;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  in_item_t  pending_items[$];
  out_item_t expected_results[$];

  logic [1:0] rx_phase;
  logic [3:0] rx_count;
  logic [7:0] rx_shift;
  logic       rx_timeout;
  logic       rx_error;

  int error_count = 0;
  int items_taken = 0;
  int results_checked = 0;
  int cycle_count = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit calm;

  ps2_host_frame_engine_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  assign calm = (items_taken >= 120) && (items_taken < 220);

  function automatic logic parity_of(input logic [7:0] b);
    logic p;
    p = 1'b1;
    for (int i = 0; i < DATA_BITS; i++) p = p ^ b[i];
    return p;
  endfunction

  function automatic void push_drive(input logic level, input logic fin);
    out_item_t r;
    r = '0;
    r.result_kind  = KIND_TX;
    r.parity_error = rx_error;
    r.line_level   = level;
    r.last         = fin;
    expected_results.push_back(r);
  endfunction

  function automatic void predict_item(input in_item_t it);
    out_item_t r;
    r = '0;
    case (it.req_type)
      REQ_RX_BIT: begin
        if (rx_timeout || rx_phase == PHASE_IDLE) begin
          if (!it.rx_bit) begin
            rx_phase = PHASE_DATA;
            rx_count = '0;
            rx_shift = '0;
          end
        end else if (rx_phase == PHASE_DATA) begin
          if (it.rx_bit) rx_shift[rx_count[2:0]] = 1'b1;
          rx_count = rx_count + 4'd1;
          if (rx_count >= DATA_BITS) rx_phase = PHASE_PARITY;
        end else if (rx_phase == PHASE_PARITY) begin
          if (it.rx_bit == parity_of(rx_shift)) begin
            r.byte_valid = 1'b1;
            r.rx_byte    = rx_shift;
          end else begin
            rx_error = 1'b1;
          end
          rx_phase = PHASE_STOP;
        end else begin
          rx_phase = PHASE_IDLE;
        end
        rx_timeout     = 1'b0;
        r.result_kind  = KIND_RX;
        r.parity_error = rx_error;
        r.line_level   = 1'b1;
        r.last         = 1'b1;
        expected_results.push_back(r);
      end
      REQ_TIMEOUT: rx_timeout = 1'b1;
      REQ_SEND: begin
        push_drive(1'b0, 1'b0);
        for (int i = 0; i < DATA_BITS; i++) push_drive(it.tx_byte[i], 1'b0);
        push_drive(parity_of(it.tx_byte), 1'b0);
        push_drive(1'b1, 1'b1);
        rx_timeout = 1'b1;
      end
      default: ;
    endcase
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      rx_phase = PHASE_IDLE;
      rx_count = '0;
      rx_shift = '0;
      rx_timeout = 1'b0;
      rx_error = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_item(in_data);
        items_taken++;
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          in_data  <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: item with none expected, actual %0h", $time, out_data);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("result_kind", 8'(want.result_kind), 8'(out_data.result_kind));
          check_field("byte_valid", 8'(want.byte_valid), 8'(out_data.byte_valid));
          check_field("rx_byte", want.rx_byte, out_data.rx_byte);
          check_field("parity_error", 8'(want.parity_error), 8'(out_data.parity_error));
          check_field("line_level", 8'(want.line_level), 8'(out_data.line_level));
          check_field("last", 8'(want.last), 8'(out_data.last));
        end
        results_checked++;
      end
      if (!hold_done && results_checked >= 60) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ps2_host_frame_engine_unit: mismatch");
      $finish;
    end
  end

  task automatic push_item(input logic [1:0] req, input logic b, input logic [7:0] data);
    in_item_t it;
    it.req_type = req;
    it.rx_bit   = b;
    it.tx_byte  = data;
    pending_items.push_back(it);
  endtask

  task automatic push_bits(input logic [7:0] data, input int count);
    for (int i = 0; i < count; i++) push_item(REQ_RX_BIT, data[i], 8'($urandom));
  endtask

  task automatic push_frame(input logic [7:0] data, input bit good, input logic stop_bit);
    push_item(REQ_RX_BIT, 1'b0, 8'($urandom));
    push_bits(data, DATA_BITS);
    push_item(REQ_RX_BIT, good ? parity_of(data) : ~parity_of(data), 8'($urandom));
    push_item(REQ_RX_BIT, stop_bit, 8'($urandom));
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic push_random(input int target);
    int made;
    int pick;
    int cut;
    made = 0;
    while (made < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        push_frame(8'($urandom), $urandom_range(0, 9) != 0, 1'($urandom_range(0, 1)));
        made += 11;
      end else if (pick < 62) begin
        cut = $urandom_range(1, 8);
        push_item(REQ_RX_BIT, 1'b0, 8'($urandom));
        push_bits(8'($urandom), cut);
        push_item(REQ_TIMEOUT, 1'($urandom_range(0, 1)), 8'($urandom));
        made += cut + 2;
      end else if (pick < 76) begin
        push_item(REQ_SEND, 1'($urandom_range(0, 1)), 8'($urandom));
        made++;
      end else if (pick < 85) begin
        push_item(REQ_TIMEOUT, 1'($urandom_range(0, 1)), 8'($urandom));
        made++;
      end else if (pick < 96) begin
        push_item(REQ_RX_BIT, 1'($urandom_range(0, 1)), 8'($urandom));
        made++;
      end else begin
        push_item(REQ_UNUSED, 1'($urandom_range(0, 1)), 8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_item(REQ_RX_BIT, 1'b1, 8'h00);
    push_frame(8'hff, 1'b1, 1'b0);
    push_item(REQ_SEND, 1'b0, 8'h00);
    push_item(REQ_SEND, 1'b1, 8'hff);
    push_item(REQ_UNUSED, 1'b1, 8'hff);
    push_item(REQ_RX_BIT, 1'b0, 8'hff);
    push_bits(8'h05, 3);
    push_item(REQ_TIMEOUT, 1'b0, 8'h00);
    push_item(REQ_RX_BIT, 1'b1, 8'h00);
    push_item(REQ_TIMEOUT, 1'b1, 8'h00);
    push_item(REQ_RX_BIT, 1'b0, 8'h00);
    wait_drained();

    push_random(200);
    wait_drained();

    push_random(200);
    wait_drained();

    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("ps2_host_frame_engine_unit: match");
    end else begin
      $display("ps2_host_frame_engine_unit: mismatch");
    end
    $finish;
  end

endmodule
